>>> rtl/isu_pkg.sv
// isu_pkg: shared types and constants of the isotropic stress update block
// fixed field widths, register indexes and reset values, pipeline stage map
// used by every rtl file of the block but isu_out_if, depends on nothing
`default_nettype none

package isu_pkg;

    // fixed field widths
    localparam int RATE_W    = 32;                  // strain rate, Q1.30
    localparam int MU_W      = 32;                  // shear modulus, integer Pa
    localparam int LAM_W     = 33;                  // lambda, signed integer Pa
    localparam int DT_W      = 32;                  // time step, Q0.32
    localparam int ITAU_W    = 32;                  // 1/tau, Q16.16
    localparam int TR_W      = RATE_W + 2;          // sum of three rates
    localparam int MR_W      = MU_W + RATE_W + 1;   // mu * rate
    localparam int LT_W      = LAM_W + TR_W;        // lambda * trace
    localparam int SCALE_SH  = 48;                  // Q.64 sum back to Q.16

    // configuration port
    localparam int CFG_W     = 33;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_MU     = 3'd1,
        REG_LAMBDA = 3'd2,
        REG_DT     = 3'd3,
        REG_ITAU   = 3'd4
    } t_reg_idx;

    localparam logic             MODE_ELASTIC = 1'b0;
    localparam logic             MODE_MAXWELL = 1'b1;
    localparam logic [MU_W-1:0]   MU_RST   = 32'd384615;
    localparam logic [LAM_W-1:0]  LAM_RST  = 33'd576923;
    localparam logic [DT_W-1:0]   DT_RST   = 32'd0;
    localparam logic [ITAU_W-1:0] ITAU_RST = 32'd65536;

    typedef struct packed {
        logic              mode;
        logic [MU_W-1:0]   mu;
        logic [LAM_W-1:0]  lambda;  // two's complement
        logic [DT_W-1:0]   dt;
        logic [ITAU_W-1:0] itau;
    } t_cfg;

    // pipeline stage map
    localparam int ST_IN      = 0;  // input capture
    localparam int ST_MUL     = 1;  // mu*rate, stress*itau partials, trace
    localparam int ST_SUM     = 2;  // viscous term sum, lambda*trace
    localparam int ST_DIFF    = 3;  // rate term minus viscous term
    localparam int ST_DT      = 4;  // partial products with dt
    localparam int ST_ACC     = 5;  // partial product sum
    localparam int ST_OUT     = 6;  // round, clip, result register
    localparam int NUM_STAGES = 7;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;  // stage takes new contents
        logic [NUM_STAGES-1:0] vld;   // stage holds an item
    } t_pipe_ctl;

endpackage

`default_nettype wire

>>> rtl/isu_in_if.sv
// isu_in_if: input channel of the stress update, one particle per transfer
// valid/ready handshake with old stress and strain rate tensors
// depends on isu_pkg
`default_nettype none

interface isu_in_if #(
    parameter int STRESS_BITS = 48
);
    logic                                valid;
    logic                                ready;
    logic signed [STRESS_BITS-1:0]       stress_xx;
    logic signed [STRESS_BITS-1:0]       stress_yy;
    logic signed [STRESS_BITS-1:0]       stress_zz;
    logic signed [STRESS_BITS-1:0]       stress_xy;
    logic signed [STRESS_BITS-1:0]       stress_yz;
    logic signed [STRESS_BITS-1:0]       stress_xz;
    logic signed [isu_pkg::RATE_W-1:0]   rate_xx;
    logic signed [isu_pkg::RATE_W-1:0]   rate_yy;
    logic signed [isu_pkg::RATE_W-1:0]   rate_zz;
    logic signed [isu_pkg::RATE_W-1:0]   rate_xy;
    logic signed [isu_pkg::RATE_W-1:0]   rate_yz;
    logic signed [isu_pkg::RATE_W-1:0]   rate_xz;

    modport source (
        output valid, stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz,
        output rate_xx, rate_yy, rate_zz, rate_xy, rate_yz, rate_xz,
        input  ready
    );
    modport sink (
        input  valid, stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz,
        input  rate_xx, rate_yy, rate_zz, rate_xy, rate_yz, rate_xz,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/isu_out_if.sv
// isu_out_if: result channel of the stress update, one particle per transfer
// valid/ready handshake with new stress tensor and saturation flag
// depends on nothing
`default_nettype none

interface isu_out_if #(
    parameter int STRESS_BITS = 48
);
    logic                          valid;
    logic                          ready;
    logic signed [STRESS_BITS-1:0] new_stress_xx;
    logic signed [STRESS_BITS-1:0] new_stress_yy;
    logic signed [STRESS_BITS-1:0] new_stress_zz;
    logic signed [STRESS_BITS-1:0] new_stress_xy;
    logic signed [STRESS_BITS-1:0] new_stress_yz;
    logic signed [STRESS_BITS-1:0] new_stress_xz;
    logic                          saturated;

    modport source (
        output valid, new_stress_xx, new_stress_yy, new_stress_zz,
        output new_stress_xy, new_stress_yz, new_stress_xz, saturated,
        input  ready
    );
    modport sink (
        input  valid, new_stress_xx, new_stress_yy, new_stress_zz,
        input  new_stress_xy, new_stress_yz, new_stress_xz, saturated,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/isu_cfg_regs.sv
// isu_cfg_regs: configuration registers (mode, mu, lambda, dt, 1/tau)
// plain write port, writes beyond the last index are dropped
// depends on isu_pkg
`default_nettype none

module isu_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [isu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [isu_pkg::CFG_W-1:0]       i_cfg_data,
    output isu_pkg::t_cfg                        o_cfg
);

    isu_pkg::t_cfg r_cfg;
    isu_pkg::t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (isu_pkg::t_reg_idx'(i_cfg_idx))
                isu_pkg::REG_MODE:   n_cfg.mode   = i_cfg_data[0];
                isu_pkg::REG_MU:     n_cfg.mu     = i_cfg_data[isu_pkg::MU_W-1:0];
                isu_pkg::REG_LAMBDA: n_cfg.lambda = i_cfg_data[isu_pkg::LAM_W-1:0];
                isu_pkg::REG_DT:     n_cfg.dt     = i_cfg_data[isu_pkg::DT_W-1:0];
                isu_pkg::REG_ITAU:   n_cfg.itau   = i_cfg_data[isu_pkg::ITAU_W-1:0];
                default:             n_cfg        = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= isu_pkg::MODE_ELASTIC;
            r_cfg.mu     <= isu_pkg::MU_RST;
            r_cfg.lambda <= isu_pkg::LAM_RST;
            r_cfg.dt     <= isu_pkg::DT_RST;
            r_cfg.itau   <= isu_pkg::ITAU_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/isu_pipe_ctrl.sv
// isu_pipe_ctrl: valid bits and per-stage load enables of the update pipeline
// a stage loads when it is empty or its successor loads, the last one on ready
// depends on isu_pkg
`default_nettype none

module isu_pipe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output isu_pkg::t_pipe_ctl o_ctl
);

    localparam int NS = isu_pkg::NUM_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] v_load;

    // load enables ripple back from the output
    always_comb begin
        v_load[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            v_load[k] = !r_vld[k] || v_load[k+1];
        end
    end

    // valid bits follow their items
    always_comb begin
        n_vld = r_vld;
        if (v_load[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (v_load[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = v_load[0];
    assign o_out_valid = r_vld[NS-1];
    assign o_ctl.load  = v_load;
    assign o_ctl.vld   = r_vld;

    // an input transfer always lands in the first stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("input transfer not captured in first stage");

    // back-pressure reaches the input only when every stage is full
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // the output stage, when it loads, takes its predecessor's valid bit
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_load[isu_pkg::ST_OUT] |=> (r_vld[isu_pkg::ST_OUT] == $past(r_vld[isu_pkg::ST_ACC])))
        else $error("output stage valid bit lost or duplicated");

endmodule

`default_nettype wire

>>> rtl/isu_trace.sv
// isu_trace: shared diagonal term, trace of the strain rate times lambda
// trace registered in the multiply stage, lambda product in the sum stage
// depends on isu_pkg
`default_nettype none

module isu_trace (
    input  wire logic                                 i_clk,
    input  wire isu_pkg::t_pipe_ctl                   i_ctl,
    input  wire isu_pkg::t_cfg                        i_cfg,
    input  wire logic signed [isu_pkg::RATE_W-1:0]    i_rate_xx,
    input  wire logic signed [isu_pkg::RATE_W-1:0]    i_rate_yy,
    input  wire logic signed [isu_pkg::RATE_W-1:0]    i_rate_zz,
    output logic signed [isu_pkg::LT_W-1:0]           o_lt
);

    localparam int TW = isu_pkg::TR_W;

    logic signed [TW-1:0]              r_tr;
    logic signed [isu_pkg::LT_W-1:0]   r_lt;
    logic signed [TW-1:0]              v_tr;
    logic signed [isu_pkg::LT_W-1:0]   v_lt;

    // trace of the rate tensor
    assign v_tr = TW'(i_rate_xx) + TW'(i_rate_yy) + TW'(i_rate_zz);

    // lambda * trace, 33 x 34 signed
    assign v_lt = $signed(i_cfg.lambda) * r_tr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[isu_pkg::ST_MUL]) begin
            r_tr <= v_tr;
        end
        if (i_ctl.load[isu_pkg::ST_SUM]) begin
            r_lt <= v_lt;
        end
    end

    assign o_lt = r_lt;

endmodule

`default_nettype wire

>>> rtl/isu_lane.sv
// isu_lane: datapath of one stress component through all pipeline stages
// rate term, optional Maxwell relaxation, dt scaling, rounding and clipping
// depends on isu_pkg; load enables come from isu_pipe_ctrl
`default_nettype none

module isu_lane #(
    parameter int STRESS_BITS = 48
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire isu_pkg::t_pipe_ctl                   i_ctl,
    input  wire isu_pkg::t_cfg                        i_cfg,
    input  wire logic signed [STRESS_BITS-1:0]        i_stress,
    input  wire logic signed [isu_pkg::RATE_W-1:0]    i_rate,
    input  wire logic signed [isu_pkg::LT_W-1:0]      i_lt,
    output logic signed [isu_pkg::RATE_W-1:0]         o_rate,
    output logic signed [STRESS_BITS-1:0]             o_stress,
    output logic                                      o_sat
);

    localparam int SB    = STRESS_BITS;
    localparam int SL    = SB / 2;                 // low part of stress split
    localparam int SH    = SB - SL;                // high part, signed
    localparam int LOW   = SL + isu_pkg::ITAU_W;
    localparam int HIW   = SH + isu_pkg::ITAU_W + 1;
    localparam int SIT_W = SB + isu_pkg::ITAU_W + 1;
    localparam int RT_W  = isu_pkg::LT_W + 2;      // 4*lambda*trace
    localparam int DW    = ((SIT_W > RT_W) ? SIT_W : RT_W) + 2;
    localparam int NCH   = (DW + 31) / 32;         // 32-bit chunks of d
    localparam int LASTW = DW - 32 * (NCH - 1);
    localparam int PPW   = 32 + isu_pkg::DT_W;
    localparam int PLW   = LASTW + isu_pkg::DT_W + 1;
    localparam int PSW   = DW + isu_pkg::DT_W + 1;
    localparam int XW    = PSW + 1;
    localparam int YW    = XW - isu_pkg::SCALE_SH;

    localparam logic signed [SB-1:0] MAXV = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] MINV = {1'b1, {(SB-1){1'b0}}};

    // stress shift line, one tap per stage up to the accumulate stage
    logic signed [SB-1:0]                 r_s [isu_pkg::ST_OUT];
    logic signed [isu_pkg::RATE_W-1:0]    r_r0;
    logic signed [isu_pkg::MR_W-1:0]      r_mr1;
    logic        [LOW-1:0]                r_lo1;
    logic signed [HIW-1:0]                r_hi1;
    logic signed [isu_pkg::MR_W-1:0]      r_mr2;
    logic signed [SIT_W-1:0]              r_sit2;
    logic signed [DW-1:0]                 r_d3;
    logic        [PPW-1:0]                r_pp4 [NCH-1];
    logic signed [PLW-1:0]                r_ppl4;
    logic signed [PSW-1:0]                r_sum5;
    logic signed [SB-1:0]                 r_res6;
    logic                                 r_sat6;

    logic signed [isu_pkg::MR_W-1:0]      v_mr;
    logic        [LOW-1:0]                v_lo;
    logic signed [HIW-1:0]                v_hi;
    logic signed [SIT_W-1:0]              v_sit;
    logic signed [DW-1:0]                 v_visc;
    logic signed [DW-1:0]                 v_d;
    logic        [PPW-1:0]                v_pp [NCH-1];
    logic signed [PLW-1:0]                v_ppl;
    logic signed [PSW-1:0]                v_sum;
    logic signed [XW-1:0]                 v_x;
    logic signed [YW-1:0]                 v_y;
    logic        [YW-SB:0]                v_top;
    logic                                 v_ovf;
    logic signed [SB-1:0]                 v_res;

    // multiply stage: mu*rate and the two halves of stress*itau
    assign v_mr = $signed({1'b0, i_cfg.mu}) * r_r0;
    assign v_lo = r_s[isu_pkg::ST_IN][SL-1:0] * i_cfg.itau;
    assign v_hi = $signed(r_s[isu_pkg::ST_IN][SB-1:SL]) * $signed({1'b0, i_cfg.itau});

    // sum stage: join the stress*itau halves
    assign v_sit = (SIT_W'(r_hi1) <<< SL) + SIT_W'(r_lo1);

    // difference stage: 4*(2*mu*rate + lambda*trace) minus the viscous term
    assign v_visc = (i_cfg.mode == isu_pkg::MODE_MAXWELL) ? DW'(r_sit2) : '0;
    assign v_d    = (DW'(r_mr2) <<< 3) + (DW'(i_lt) <<< 2) - v_visc;

    // dt stage: d split in 32-bit chunks, top chunk signed
    always_comb begin
        for (int k = 0; k < NCH - 1; k++) begin
            v_pp[k] = r_d3[32*k +: 32] * i_cfg.dt;
        end
    end
    assign v_ppl = $signed(r_d3[DW-1 -: LASTW]) * $signed({1'b0, i_cfg.dt});

    // accumulate stage: weighted sum of the chunk products
    always_comb begin
        v_sum = PSW'(r_ppl4) <<< (32 * (NCH - 1));
        for (int k = 0; k < NCH - 1; k++) begin
            v_sum = v_sum + (PSW'(r_pp4[k]) << (32 * k));
        end
    end

    // output stage: add old stress, round half up, clip to stress range
    assign v_x   = XW'(r_sum5) + (XW'(r_s[isu_pkg::ST_ACC]) <<< isu_pkg::SCALE_SH)
                 + (XW'(1) <<< (isu_pkg::SCALE_SH - 1));
    assign v_y   = YW'(v_x >>> isu_pkg::SCALE_SH);
    assign v_top = v_y[YW-1:SB-1];
    assign v_ovf = !((&v_top) || !(|v_top));
    assign v_res = v_ovf ? (v_y[YW-1] ? MINV : MAXV) : v_y[SB-1:0];

    // stage registers, each loads on its own enable
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[isu_pkg::ST_IN]) begin
            r_s[isu_pkg::ST_IN] <= i_stress;
            r_r0                <= i_rate;
        end
        for (int k = isu_pkg::ST_MUL; k < isu_pkg::ST_OUT; k++) begin
            if (i_ctl.load[k]) begin
                r_s[k] <= r_s[k-1];
            end
        end
        if (i_ctl.load[isu_pkg::ST_MUL]) begin
            r_mr1 <= v_mr;
            r_lo1 <= v_lo;
            r_hi1 <= v_hi;
        end
        if (i_ctl.load[isu_pkg::ST_SUM]) begin
            r_mr2  <= r_mr1;
            r_sit2 <= v_sit;
        end
        if (i_ctl.load[isu_pkg::ST_DIFF]) begin
            r_d3 <= v_d;
        end
        if (i_ctl.load[isu_pkg::ST_DT]) begin
            r_pp4  <= v_pp;
            r_ppl4 <= v_ppl;
        end
        if (i_ctl.load[isu_pkg::ST_ACC]) begin
            r_sum5 <= v_sum;
        end
        if (i_ctl.load[isu_pkg::ST_OUT]) begin
            r_res6 <= v_res;
            r_sat6 <= v_ovf;
        end
    end

    assign o_rate   = r_r0;
    assign o_stress = r_res6;
    assign o_sat    = r_sat6;

    // a clipped result sits exactly on one of the range bounds
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.vld[isu_pkg::ST_OUT] && r_sat6) |-> (r_res6 == MAXV || r_res6 == MINV))
        else $error("saturated result not at a range bound");

endmodule

`default_nettype wire

>>> rtl/isotropic_stress_update.sv
// isotropic_stress_update: one explicit Euler stress step per particle
//
// Input channel i_item carries the old stress (six Q31.16 components) and the
// strain rate (six Q1.30 components); output channel o_result carries the new
// stress and a flag set when any component was clipped. Both use valid/ready,
// a transfer happens on a clock edge with both high.
// Configuration (mode, mu, lambda, dt, 1/tau) is written through i_cfg_we/
// i_cfg_idx/i_cfg_data; the user must write it only while no item is in
// flight, the block does not enforce this. Pipeline of seven register stages;
// one item is taken every cycle while the input is not stalled. The depth is
// set by the dt product, which is formed from 32-bit partial products and
// summed in a stage of its own, followed by rounding and clipping.
// When o_result.ready is low, items pile up in the empty stages; the input
// stalls only once all seven stages are full, nothing is dropped or repeated.
// Synchronous reset empties the pipeline and loads the register defaults
// (elastic mode, mu 384615, lambda 576923, dt 0, 1/tau 1.0).
// depends on isu_pkg, isu_in_if, isu_out_if and the isu_* submodules
`default_nettype none

module isotropic_stress_update #(
    parameter int STRESS_BITS = 48
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    isu_in_if.sink                               i_item,
    isu_out_if.source                            o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [isu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [isu_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int NLANE = 6;
    localparam int NDIAG = 3;

    isu_pkg::t_cfg       v_cfg;
    isu_pkg::t_pipe_ctl  v_ctl;
    logic                v_in_ready;
    logic                v_out_valid;

    logic signed [STRESS_BITS-1:0]       v_s_in  [NLANE];
    logic signed [isu_pkg::RATE_W-1:0]   v_r_in  [NLANE];
    logic signed [isu_pkg::RATE_W-1:0]   v_r_st0 [NLANE];
    logic signed [isu_pkg::LT_W-1:0]     v_lt;
    logic signed [isu_pkg::LT_W-1:0]     v_lane_lt [NLANE];
    logic signed [STRESS_BITS-1:0]       v_res   [NLANE];
    logic        [NLANE-1:0]             v_sat;

    // component order xx, yy, zz, xy, yz, xz
    assign v_s_in[0] = i_item.stress_xx;
    assign v_s_in[1] = i_item.stress_yy;
    assign v_s_in[2] = i_item.stress_zz;
    assign v_s_in[3] = i_item.stress_xy;
    assign v_s_in[4] = i_item.stress_yz;
    assign v_s_in[5] = i_item.stress_xz;
    assign v_r_in[0] = i_item.rate_xx;
    assign v_r_in[1] = i_item.rate_yy;
    assign v_r_in[2] = i_item.rate_zz;
    assign v_r_in[3] = i_item.rate_xy;
    assign v_r_in[4] = i_item.rate_yz;
    assign v_r_in[5] = i_item.rate_xz;

    // configuration registers
    isu_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (v_cfg)
    );

    // pipeline flow control
    isu_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (v_in_ready),
        .o_out_valid (v_out_valid),
        .o_ctl       (v_ctl)
    );

    // lambda * trace, shared by the diagonal lanes
    isu_trace u_trace (
        .i_clk     (i_clk),
        .i_ctl     (v_ctl),
        .i_cfg     (v_cfg),
        .i_rate_xx (v_r_st0[0]),
        .i_rate_yy (v_r_st0[1]),
        .i_rate_zz (v_r_st0[2]),
        .o_lt      (v_lt)
    );

    // one lane per stress component, shear lanes get no lambda term
    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        assign v_lane_lt[g] = (g < NDIAG) ? v_lt : '0;

        isu_lane #(
            .STRESS_BITS (STRESS_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (v_ctl),
            .i_cfg    (v_cfg),
            .i_stress (v_s_in[g]),
            .i_rate   (v_r_in[g]),
            .i_lt     (v_lane_lt[g]),
            .o_rate   (v_r_st0[g]),
            .o_stress (v_res[g]),
            .o_sat    (v_sat[g])
        );
    end

    // channel outputs
    assign i_item.ready           = v_in_ready;
    assign o_result.valid         = v_out_valid;
    assign o_result.new_stress_xx = v_res[0];
    assign o_result.new_stress_yy = v_res[1];
    assign o_result.new_stress_zz = v_res[2];
    assign o_result.new_stress_xy = v_res[3];
    assign o_result.new_stress_yz = v_res[4];
    assign o_result.new_stress_xz = v_res[5];
    assign o_result.saturated     = |v_sat;

endmodule

`default_nettype wire
